// ===== hw/rtl/tpsp_pkg.sv =====
`default_nettype none

package tpsp_pkg;

  // Angle code width and quarter-wave table size (table size is a power of two)
  localparam int ANGLE_BITS        = 16;
  localparam int SINE_DEPTH_LOG2   = 10;
  localparam int SINE_TABLE_DEPTH  = 1 << SINE_DEPTH_LOG2;
  localparam int SINE_ROM_ENTRIES  = SINE_TABLE_DEPTH + 1;
  localparam int ADDR_BITS         = SINE_DEPTH_LOG2 + 1;
  localparam int MAG_BITS          = 15;

  localparam int IN_BITS   = 16;
  localparam int CMP_BITS  = 16;
  localparam int OUT_BYTES = (3 * CMP_BITS + 3 + 7) / 8;
  localparam int OUT_BITS  = OUT_BYTES * 8;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PWM_PERIOD = 2'd1;

  // ROM write beat from the fill sequencer
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [MAG_BITS-1:0]  data;
  } rom_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpsp_ram.sv =====
`default_nettype none

module tpsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpsp_sine_fill.sv =====
`default_nettype none

// Builds the quarter-wave table after reset: odd Q30 polynomial in Horner
// form on one shared multiplier, stepping square, K11 down to K1, scale and write for each entry.
module tpsp_sine_fill
  import tpsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  output rom_wr_t   wr,
  output logic      done
);

  localparam logic [30:0] K1  = 31'd1686629713;
  localparam logic [30:0] K3  = 31'd693598668;
  localparam logic [30:0] K5  = 31'd85569306;
  localparam logic [30:0] K7  = 31'd5026995;
  localparam logic [30:0] K9  = 31'd172275;
  localparam logic [30:0] K11 = 31'd3864;
  localparam logic [30:0] FULL_SCALE = 31'd32767;
  localparam int          X_SHIFT    = 30 - SINE_DEPTH_LOG2;

  localparam logic [3:0] STEP_SQUARE = 4'd0;
  localparam logic [3:0] STEP_K11    = 4'd1;
  localparam logic [3:0] STEP_K9     = 4'd2;
  localparam logic [3:0] STEP_K7     = 4'd3;
  localparam logic [3:0] STEP_K5     = 4'd4;
  localparam logic [3:0] STEP_K3     = 4'd5;
  localparam logic [3:0] STEP_K1     = 4'd6;
  localparam logic [3:0] STEP_SCALE  = 4'd7;
  localparam logic [3:0] STEP_WRITE  = 4'd8;

  logic [ADDR_BITS-1:0] index;
  logic [3:0]           step;
  logic [61:0]          prod;
  logic [61:0]          prod_next;
  logic [30:0]          x2;
  logic [30:0]          x_cur;
  logic [30:0]          prod_hi;
  logic [30:0]          mul_a;
  logic [30:0]          mul_b;
  logic [61:0]          rounded;
  logic [31:0]          level;
  logic [MAG_BITS-1:0]  mag;

  always_comb begin
    x_cur   = 31'(index) << X_SHIFT;
    prod_hi = 31'(prod >> 30);
    case (step)
      STEP_SQUARE: begin mul_a = x_cur;          mul_b = x_cur;      end
      STEP_K11:    begin mul_a = K11;            mul_b = prod_hi;    end
      STEP_K9:     begin mul_a = K9 - prod_hi;   mul_b = x2;         end
      STEP_K7:     begin mul_a = K7 - prod_hi;   mul_b = x2;         end
      STEP_K5:     begin mul_a = K5 - prod_hi;   mul_b = x2;         end
      STEP_K3:     begin mul_a = K3 - prod_hi;   mul_b = x2;         end
      STEP_K1:     begin mul_a = K1 - prod_hi;   mul_b = x_cur;      end
      STEP_SCALE:  begin mul_a = prod_hi;        mul_b = FULL_SCALE; end
      default:     begin mul_a = '0;             mul_b = '0;         end
    endcase
    prod_next = 62'(mul_a) * 62'(mul_b);
    // round to Q0.15 and clip at full scale
    rounded = prod + (62'd1 << 29);
    level   = rounded[61:30];
    mag     = (level > 32'(FULL_SCALE)) ? MAG_BITS'(FULL_SCALE) : level[MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
      step  <= STEP_SQUARE;
      done  <= 1'b0;
    end else if (!done) begin
      if (step == STEP_WRITE) begin
        step <= STEP_SQUARE;
        if (index == ADDR_BITS'(SINE_TABLE_DEPTH)) begin
          done <= 1'b1;
        end else begin
          index <= ADDR_BITS'(index + 1'b1);
        end
      end else begin
        step <= 4'(step + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (step == STEP_K11) begin
      x2 <= prod_hi;
    end
  end

  always_comb begin
    wr.we   = !done && (step == STEP_WRITE);
    wr.addr = index;
    wr.data = mag;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/three_phase_sine_pwm_compare.sv =====
`default_nettype none

// Channel   Dir  Beat payload                               Handshake
// s_axis    in   tdata[15:0] phase_angle                   tvalid/tready
// m_axis    out  compare a/b/c, low_side a/b/c (56 bits)   tvalid/tready
// cfg       in   cfg_index (0 amplitude, 1 pwm_period),    cfg_valid/cfg_ready
//                cfg_data[15:0]
//
// One beat per cycle while m_axis is not stalled and the table is built; a result
// is offered once its angle has passed the register stages: address, table read,
// amplitude multiply, period multiply. Each phase has its own table copy, so the
// three reads happen in one cycle. After rst the table is built, 1025 entries,
// with s_axis_tready low. cfg writes are taken at any time (cfg_ready is high).
// A stall on m_axis holds the whole pipeline in place; nothing is dropped.
module three_phase_sine_pwm_compare
  import tpsp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // phase_angle[15:0]
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [IN_BITS-1:0]        s_axis_tdata,
  // compare_a[15:0], compare_b[31:16], compare_c[47:32],
  // low_side_a[48], low_side_b[49], low_side_c[50], zero pad [55:51]
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [OUT_BITS-1:0]       m_axis_tdata,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int QUAD_BITS = ANGLE_BITS - 2;
  localparam logic [ANGLE_BITS-1:0] OFFSET_120 =
    ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);
  localparam logic [ANGLE_BITS-1:0] OFFSET_240 =
    ANGLE_BITS'(((64'd2 << ANGLE_BITS) + 64'd1) / 64'd3);

  // table address of an angle; quadrants 1 and 3 run the table backwards
  function automatic logic [ADDR_BITS-1:0] sine_addr(input logic [ANGLE_BITS-1:0] ang);
    logic [QUAD_BITS+SINE_DEPTH_LOG2-1:0] scaled;
    logic [ADDR_BITS-1:0]                 idx;
    scaled = (QUAD_BITS + SINE_DEPTH_LOG2)'(ang[QUAD_BITS-1:0]) << SINE_DEPTH_LOG2;
    idx    = ADDR_BITS'(scaled >> QUAD_BITS);
    if (ang[ANGLE_BITS-2]) begin
      return ADDR_BITS'(ADDR_BITS'(SINE_TABLE_DEPTH) - idx);
    end
    return idx;
  endfunction

  // configuration
  logic [15:0] amplitude;
  logic [15:0] pwm_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude  <= '0;
      pwm_period <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AMPLITUDE:  amplitude  <= cfg_data;
        REG_PWM_PERIOD: pwm_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // table build
  rom_wr_t rom_wr;
  logic    fill_done;

  tpsp_sine_fill u_fill (
    .clk  (clk),
    .rst  (rst),
    .wr   (rom_wr),
    .done (fill_done)
  );

  // pipeline control: whole pipe moves together unless the output is stuck
  logic v1, v2, v3, v4;
  logic advance;

  assign advance       = !v4 || m_axis_tready;
  assign s_axis_tready = advance && fill_done;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= s_axis_tvalid && fill_done;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: phase offsets and table addresses
  logic [ANGLE_BITS-1:0] ang_a, ang_b, ang_c;
  logic [ADDR_BITS-1:0]  addr1 [3];
  logic [2:0]            sgn1;

  always_comb begin
    ang_a = ANGLE_BITS'(s_axis_tdata);
    ang_b = ANGLE_BITS'(ang_a + OFFSET_120);
    ang_c = ANGLE_BITS'(ang_a + OFFSET_240);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr1[0] <= sine_addr(ang_a);
      addr1[1] <= sine_addr(ang_b);
      addr1[2] <= sine_addr(ang_c);
      sgn1     <= {ang_c[ANGLE_BITS-1], ang_b[ANGLE_BITS-1], ang_a[ANGLE_BITS-1]};
    end
  end

  // stage 2: table read, one copy per phase
  logic [MAG_BITS-1:0] mag2 [3];
  logic [2:0]          sgn2;

  for (genvar k = 0; k < 3; k++) begin : g_rom
    tpsp_ram #(
      .WIDTH (MAG_BITS),
      .DEPTH (SINE_ROM_ENTRIES)
    ) u_rom (
      .clk   (clk),
      .we    (rom_wr.we),
      .waddr (rom_wr.addr),
      .wdata (rom_wr.data),
      .re    (advance),
      .raddr (addr1[k]),
      .rdata (mag2[k])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sgn2 <= sgn1;
    end
  end

  // stage 3: |sin| * amplitude; zero sine counts as positive
  logic [30:0] prod3 [3];
  logic [2:0]  neg3;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        prod3[k] <= 31'(mag2[k]) * 31'(amplitude);
        neg3[k]  <= sgn2[k] && (mag2[k] != '0);
      end
    end
  end

  // stage 4: * pwm_period, keep bits 46:31
  logic [CMP_BITS-1:0] cmp4 [3];
  logic [2:0]          neg4;
  logic [46:0]         prod4 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod4[k] = 47'(prod3[k]) * 47'(pwm_period);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        cmp4[k] <= prod4[k][46:31];
      end
      neg4 <= neg3;
    end
  end

  assign m_axis_tdata = {(OUT_BITS - 3 * CMP_BITS - 3)'(0), neg4, cmp4[2], cmp4[1], cmp4[0]};

  // checks
  a_no_out_before_fill: assert property (@(posedge clk) disable iff (rst)
    !fill_done |-> !m_axis_tvalid)
    else $error("result beat before table build finished");

  a_fill_sticky: assert property (@(posedge clk) disable iff (rst)
    fill_done |=> fill_done)
    else $error("table build flag dropped");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && v3) |=> m_axis_tvalid)
    else $error("item lost between multiply stages");

  a_low_side_needs_mag: assert property (@(posedge clk) disable iff (rst)
    (advance && v2 && (mag2[0] == '0)) |=> !neg3[0])
    else $error("phase A low-side flag on a zero sine");

endmodule

`default_nettype wire

// ===== verif/three_phase_sine_pwm_compare_tb.sv =====
module three_phase_sine_pwm_compare_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsp_pkg::*;

  // Run limit: covers the table build after rst plus ~500 beats under heavy stalls
  // with a wide margin.
  localparam int unsigned RUN_LIMIT = 300000;
  // Pipeline is four stages deep; settle a little longer than that when idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  // Register indexes outside the map; writes to these must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  // Phase offsets in angle codes, truncated as the block does.
  localparam int unsigned TURN_CODES = 1 << ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] OFS_120 = ANGLE_BITS'((TURN_CODES + 1) / 3);
  localparam logic [ANGLE_BITS-1:0] OFS_240 = ANGLE_BITS'((2 * TURN_CODES + 1) / 3);

  // Q30 magnitudes of the odd Taylor terms of sin(pi/2 * x), used to fill the table
  localparam logic [63:0] K1  = 64'd1686629713;
  localparam logic [63:0] K3  = 64'd693598668;
  localparam logic [63:0] K5  = 64'd85569306;
  localparam logic [63:0] K7  = 64'd5026995;
  localparam logic [63:0] K9  = 64'd172275;
  localparam logic [63:0] K11 = 64'd3864;

  // One result beat, MSB first so that it lines up with m_axis_tdata[50:0]
  typedef struct packed {
    logic                ls_c;
    logic                ls_b;
    logic                ls_a;
    logic [CMP_BITS-1:0] cmp_c;
    logic [CMP_BITS-1:0] cmp_b;
    logic [CMP_BITS-1:0] cmp_a;
  } pwm_result_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  // Directed row: an angle beat (optionally with a hand-worked result) or a
  // register write.
  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [15:0]               value;
    logic                      fixed_valid;
    pwm_result_t               fixed;
  } stim_row_t;

  localparam int DIR_ROWS = 27;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_BITS-1:0]        s_axis_tdata;   // phase_angle[15:0]
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  // compare_a[15:0], compare_b[31:16], compare_c[47:32],
  // low_side_a[48], low_side_b[49], low_side_c[50], zero pad [55:51]
  logic [OUT_BITS-1:0]       m_axis_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Local copy of the register file and the quarter-wave table
  logic [15:0]         amp_setting;
  logic [15:0]         period_setting;
  logic [MAG_BITS-1:0] sine_rom [0:SINE_TABLE_DEPTH];

  pwm_result_t pending_pwm [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  bit          stall_kick;
  pwm_result_t got_beat;
  pwm_result_t want_beat;
  stim_row_t   dir_rows [DIR_ROWS];

  three_phase_sine_pwm_compare dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Horner evaluation, every product truncated back to Q30
  function automatic logic [63:0] quarter_wave_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    x2  = (x * x) >> 30;
    acc = K11;
    acc = K9 - ((acc * x2) >> 30);
    acc = K7 - ((acc * x2) >> 30);
    acc = K5 - ((acc * x2) >> 30);
    acc = K3 - ((acc * x2) >> 30);
    acc = K1 - ((acc * x2) >> 30);
    return (acc * x) >> 30;
  endfunction

  // Entry i holds round(32767 * sin(pi/2 * i / depth)), clipped to 32767
  task automatic fill_sine_rom();
    logic [63:0] x;
    logic [63:0] v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'(i) << 30) / 64'(SINE_TABLE_DEPTH);
      v = (quarter_wave_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      sine_rom[i] = v[MAG_BITS-1:0];
    end
  endtask

  // Top two angle bits pick the quadrant; odd quadrants read the table
  // backwards, the lower half-turn is positive. A zero sine is never negative.
  function automatic void sine_at(input logic [ANGLE_BITS-1:0] ang,
                                  output logic [MAG_BITS-1:0] mag,
                                  output logic neg);
    logic [1:0]  quad;
    int unsigned pos;
    int unsigned idx;
    quad = ang[ANGLE_BITS-1 -: 2];
    pos  = ang[ANGLE_BITS-3:0];
    idx  = (pos * SINE_TABLE_DEPTH) >> (ANGLE_BITS - 2);
    if (quad[0]) idx = SINE_TABLE_DEPTH - idx;
    mag = sine_rom[idx];
    neg = quad[1] && (mag != '0);
  endfunction

  // |sin| (Q0.15) x amplitude (Q0.16) x period, shifted down by 31, truncated
  function automatic logic [CMP_BITS-1:0] scaled_compare(input logic [MAG_BITS-1:0] mag);
    logic [63:0] prod;
    prod = 64'(mag) * 64'(amp_setting) * 64'(period_setting);
    return prod[46:31];
  endfunction

  function automatic pwm_result_t predict_pwm(input logic [ANGLE_BITS-1:0] ang);
    pwm_result_t         r;
    logic [MAG_BITS-1:0] mag;
    logic                neg;
    sine_at(ang, mag, neg);
    r.cmp_a = scaled_compare(mag);
    r.ls_a  = neg;
    sine_at(ang + OFS_120, mag, neg);
    r.cmp_b = scaled_compare(mag);
    r.ls_b  = neg;
    sine_at(ang + OFS_240, mag, neg);
    r.cmp_c = scaled_compare(mag);
    r.ls_c  = neg;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t item_row(input logic [15:0] ang);
    return '{kind: ROW_ITEM, reg_idx: '0, value: ang, fixed_valid: 1'b0, fixed: '0};
  endfunction

  // Known result where compare is bound to be zero: only the flags matter
  function automatic stim_row_t fixed_row(input logic [15:0] ang,
                                          input logic la, input logic lb, input logic lc);
    stim_row_t row;
    row       = item_row(ang);
    row.fixed_valid = 1'b1;
    row.fixed.ls_a  = la;
    row.fixed.ls_b  = lb;
    row.fixed.ls_c  = lc;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [15:0] data);
    return '{kind: ROW_CFG, reg_idx: idx, value: data, fixed_valid: 1'b0, fixed: '0};
  endfunction

  // Mostly full-range angles, with quadrant edges and phase offsets mixed in
  function automatic logic [15:0] rand_angle();
    logic [15:0] edges [12];
    edges = '{16'd0, 16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'd49151,
              16'd49152, 16'd65535, 16'd21844, 16'd21845, 16'd43690, 16'd43691};
    if ($urandom_range(0, 9) < 2) return edges[$urandom_range(0, 11)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (all entered and left on a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one angle beat; record its expected result once the beat is taken
  task automatic send_angle(input logic [15:0] ang, input logic use_fixed,
                            input pwm_result_t fixed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ang;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (use_fixed) pending_pwm.push_back(fixed);
    else pending_pwm.push_back(predict_pwm(ang));
    @(negedge clk);
  endtask

  // Extra falling edge after the drop so back-to-back writes never lower and
  // raise cfg_valid in one step.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_AMPLITUDE) amp_setting = data;
    else if (idx == REG_PWM_PERIOD) period_setting = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding result come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_pwm.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic retune();
    wait_idle();
    write_reg(REG_AMPLITUDE, pick_setting());
    write_reg(REG_PWM_PERIOD, pick_setting());
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
  endtask

  task automatic run_block(input int n);
    repeat (n) send_angle(rand_angle(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random back-pressure; a kick from the main sequence forces a long hold-off
  always @(negedge clk) begin
    if (stall_kick) begin
      stall_kick = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left    = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_beat = m_axis_tdata[3*CMP_BITS+2:0];
      if (pending_pwm.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing outstanding: cmp %0d %0d %0d low %b%b%b",
                   $realtime, got_beat.cmp_a, got_beat.cmp_b, got_beat.cmp_c,
                   got_beat.ls_a, got_beat.ls_b, got_beat.ls_c);
      end else begin
        want_beat = pending_pwm.pop_front();
        if (got_beat.cmp_a !== want_beat.cmp_a || got_beat.cmp_b !== want_beat.cmp_b ||
            got_beat.cmp_c !== want_beat.cmp_c || got_beat.ls_a !== want_beat.ls_a ||
            got_beat.ls_b !== want_beat.ls_b || got_beat.ls_c !== want_beat.ls_c) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected cmp %0d %0d %0d low %b%b%b, got cmp %0d %0d %0d low %b%b%b",
                     $realtime, want_beat.cmp_a, want_beat.cmp_b, want_beat.cmp_c,
                     want_beat.ls_a, want_beat.ls_b, want_beat.ls_c,
                     got_beat.cmp_a, got_beat.cmp_b, got_beat.cmp_c,
                     got_beat.ls_a, got_beat.ls_b, got_beat.ls_c);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    amp_setting    = '0;
    period_setting = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    stall_kick     = 1'b0;
    send_idle_pct  = 23;
    recv_idle_pct  = 55;
    fill_sine_rom();

    // Rows at reset settings: amplitude and period are zero, so every compare
    // is zero and only the quadrant flags carry information. A zero sine
    // (angle 0 on A, half-turn on A) must not raise the low-side flag.
    dir_rows = '{
      fixed_row(16'd0,     1'b0, 1'b0, 1'b1),
      fixed_row(16'd16384, 1'b0, 1'b1, 1'b1),
      fixed_row(16'd32768, 1'b0, 1'b1, 1'b0),
      fixed_row(16'd49152, 1'b1, 1'b0, 1'b0),
      fixed_row(16'd65535, 1'b1, 1'b0, 1'b1),
      // full scale on both registers: largest compares
      cfg_row(REG_AMPLITUDE, 16'hFFFF),
      cfg_row(REG_PWM_PERIOD, 16'hFFFF),
      item_row(16'd0),
      item_row(16'd1),
      item_row(16'd16383),
      item_row(16'd16384),
      item_row(16'd16385),
      item_row(16'd32767),
      item_row(16'd32768),
      item_row(16'd49152),
      item_row(16'd65535),
      item_row(16'h5555),
      item_row(16'hAAAA),
      // smallest non-zero scale truncates to nothing
      cfg_row(REG_AMPLITUDE, 16'd1),
      cfg_row(REG_PWM_PERIOD, 16'd1),
      fixed_row(16'd16384, 1'b0, 1'b1, 1'b1),
      // writes outside the register map leave the settings alone
      cfg_row(REG_SPARE_2, 16'hFFFF),
      cfg_row(REG_SPARE_3, 16'h5A5A),
      cfg_row(REG_AMPLITUDE, 16'h8000),
      cfg_row(REG_PWM_PERIOD, 16'd1000),
      item_row(16'd12345),
      item_row(16'd40000)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The first beat sits waiting through the table build.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].value);
      end else begin
        send_angle(dir_rows[r].value, dir_rows[r].fixed_valid, dir_rows[r].fixed);
      end
    end

    // Sender busy, receiver sparse
    repeat (4) begin
      retune();
      run_block(40);
    end

    // Sender sparse, receiver busy; sender drains mid-block each time
    send_idle_pct = 55;
    recv_idle_pct = 23;
    repeat (4) begin
      retune();
      run_block(20);
      wait_idle();
      run_block(20);
    end

    // Full rate both ways. First block opens with a long hold-off on the
    // result side so the pipeline backs up into s_axis_tready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    retune();
    @(posedge clk);
    stall_kick = 1'b1;
    @(negedge clk);
    run_block(40);
    repeat (3) begin
      retune();
      run_block(40);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_pwm.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
